### hdl/rdpd_pkg.sv
`timescale 1ns / 1ps

package rdpd_pkg;

  localparam int unsigned SETTLE_TICKS_DEF = 10;

  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned DIGIT_W    = 4;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd20;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd5000;

  localparam logic [COUNT_W-1:0] PULSES_FOR_ZERO = 4'd10;
  localparam logic [COUNT_W-1:0] PULSE_MAX       = 4'd15;
  localparam logic [COUNT_W-1:0] DIGIT_MAX       = 4'd9;
  localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_TIMEOUT  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_DIGIT   = 2'd0,
    EV_INVALID = 2'd1,
    EV_TIMEOUT = 2'd2,
    EV_HANGUP  = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_DIGIT
  } phase_t;

  typedef struct packed {
    event_kind_t             kind;
    logic [DIGIT_W-1:0]      digit;
  } result_t;

endpackage

### hdl/rotary_dial_pulse_decoder.sv
`timescale 1ns / 1ps

// rotary dial pulse decoder
// in_ channel: one contact sample per millisecond tick, in_tdata bit 0 hook
// switch (1 = handset lifted), bit 1 dial off-normal, bit 2 pulse contact.
// out_ channel: at most one event per sample; out_tuser holds the event kind
// (digit, invalid pulse count, dialing timed out, handset replaced) and
// out_tdata[3:0] the digit, zero for every kind other than a digit.
// cfg_ port: register 0 at address 0 is the debounce lockout in ticks,
// register 1 at address 4 is the idle timeout in ticks; write while idle.
// throughput: one sample per clock cycle while in_tready is high; all state
// is updated in the cycle of the transaction by one pass of counter and compare logic.
// each event is registered and is presented on out_ from the output register.
// when the receiver stalls, one event waits in the output register and a
// second in a skid register; in_tready drops only while the skid is full.
// reset (rst_n low, synchronous) closes any session, clears the counters,
// empties both output stages and loads the register defaults 20 and 5000.
module rotary_dial_pulse_decoder #(
  parameter int unsigned SETTLE_TICKS = rdpd_pkg::SETTLE_TICKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // handset_lifted, dial_turned, pulse_level
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // digit_value
  output logic [1:0]                        out_tuser,  // event_kind
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rdpd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [rdpd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [rdpd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import rdpd_pkg::*;

  localparam logic [COUNT_W-1:0] SETTLE_LIM = COUNT_W'(SETTLE_TICKS);

  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [TIMEOUT_W-1:0]  timeout_r;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_W-1:0]    settle_r, settle_nxt;
  logic                  level_r, level_nxt;
  logic [COUNT_W-1:0]    pulse_r, pulse_nxt;
  logic [DEBOUNCE_W-1:0] lockout_r, lockout_nxt;
  logic [TIMEOUT_W-1:0]  idle_r, idle_nxt;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;

  logic    accept, push;
  logic    lifted, turned, level;
  logic    cfg_write;
  result_t res;
  reg_index_t cfg_index;

  assign lifted = in_tdata[0];
  assign turned = in_tdata[1];
  assign level  = in_tdata[2];

  assign in_tready = ~skid_valid_r;
  assign accept    = in_tvalid & in_tready;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_index  = reg_index_t'(cfg_paddr[2]);

  always_comb begin
    unique case (cfg_index)
      REG_DEBOUNCE: cfg_prdata = CFG_DATA_W'(debounce_r);
      REG_TIMEOUT:  cfg_prdata = CFG_DATA_W'(timeout_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_pwdata[DEBOUNCE_W-1:0];
        REG_TIMEOUT:  timeout_r  <= cfg_pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // session phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (lifted) phase_nxt = PH_WAIT;
        end
        PH_WAIT: begin
          if (!lifted || idle_r >= timeout_r) phase_nxt = PH_IDLE;
          else if (turned)                    phase_nxt = PH_DIGIT;
        end
        PH_DIGIT: begin
          if (settle_r >= SETTLE_LIM && !turned) phase_nxt = PH_WAIT;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // counters and result
  always_comb begin
    settle_nxt  = settle_r;
    level_nxt   = level_r;
    pulse_nxt   = pulse_r;
    lockout_nxt = lockout_r;
    idle_nxt    = idle_r;
    push        = 1'b0;
    res.kind    = EV_DIGIT;
    res.digit   = '0;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (lifted) idle_nxt = '0;
        end
        PH_WAIT: begin
          if (!lifted || idle_r >= timeout_r) begin
            settle_nxt  = '0;
            level_nxt   = 1'b1;
            pulse_nxt   = '0;
            lockout_nxt = '0;
            idle_nxt    = '0;
            push        = 1'b1;
            res.kind    = lifted ? EV_TIMEOUT : EV_HANGUP;
          end else if (turned) begin
            settle_nxt  = '0;
            level_nxt   = 1'b1;
            pulse_nxt   = '0;
            lockout_nxt = '0;
          end else if (idle_r != IDLE_MAX) begin
            idle_nxt = idle_r + 1'b1;
          end
        end
        PH_DIGIT: begin
          if (settle_r < SETTLE_LIM) begin
            settle_nxt = settle_r + 1'b1;
          end else if (!turned) begin
            idle_nxt = '0;
            push     = 1'b1;
            if (pulse_r == PULSES_FOR_ZERO) begin
              res.kind = EV_DIGIT;
            end else if (pulse_r != '0 && pulse_r <= DIGIT_MAX) begin
              res.kind  = EV_DIGIT;
              res.digit = pulse_r;
            end else begin
              res.kind = EV_INVALID;
            end
          end else if (lockout_r != '0) begin
            lockout_nxt = lockout_r - 1'b1;
          end else if (level != level_r) begin
            level_nxt   = level;
            lockout_nxt = debounce_r;
            if (level && pulse_r != PULSE_MAX) pulse_nxt = pulse_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      settle_r  <= '0;
      level_r   <= 1'b1;
      pulse_r   <= '0;
      lockout_r <= '0;
      idle_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      settle_r  <= settle_nxt;
      level_r   <= level_nxt;
      pulse_r   <= pulse_nxt;
      lockout_r <= lockout_nxt;
      idle_r    <= idle_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) out_data_r <= skid_data_r;
      else if (push)    out_data_r <= res;
    end else if (push) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-DIGIT_W){1'b0}}, out_data_r.digit};
  assign out_tuser  = out_data_r.kind;

endmodule
